>>> rtl/core/b2d_pkg.sv
// shared constants and types for the binary to decimal ascii converter
package b2d_pkg;

    // default widths of the top level
    localparam int VALUE_BITS_DEF      = 31;
    localparam int DIGIT_POSITIONS_DEF = 10;

    // width of one bcd digit and of one output character
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 6;

    // ascii code of the character zero, as carried on the output
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // double dabble adjust threshold and offset
    localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

    // binary bits folded into the bcd digits per converter cycle
    localparam int BITS_PER_STEP = 4;

    // items held between the front and the converter (power of two)
    localparam int QUEUE_DEPTH = 2;

    // status of the head of the item queue
    typedef struct packed {
        logic valid;
        logic zero;
    } q_status_t;

endpackage

>>> rtl/core/b2d_front.sv
// front part: item intake, zero classification and the item queue
module b2d_front #(
    parameter int VALUE_BITS = b2d_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] value,
    output b2d_pkg::q_status_t    q_status,
    output logic [VALUE_BITS-1:0] q_value,
    input  logic                  pop
);
    import b2d_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = PTR_W + 1;

    logic [VALUE_BITS-1:0] slot_value_reg [QUEUE_DEPTH];
    logic                  slot_zero_reg  [QUEUE_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  push;

    // intake handshake: the queue refuses items only when full
    assign busy = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push = start && !busy;

    // head of the queue towards the converter
    assign q_status.valid = (count_reg != '0);
    assign q_status.zero  = slot_zero_reg[rd_ptr_reg];
    assign q_value        = slot_value_reg[rd_ptr_reg];

    // pointer and fill count update, depth is a power of two so pointers wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // item storage, classified as zero on the way in
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_value_reg[wr_ptr_reg] <= value;
            slot_zero_reg[wr_ptr_reg]  <= (value == '0);
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("item queue overfilled");

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (count_reg != '0))
        else $error("accepted item not held in queue");
`endif

endmodule

>>> rtl/core/b2d_conv.sv
// back part, first stage: double dabble conversion to bcd digits
module b2d_conv #(
    parameter int VALUE_BITS      = b2d_pkg::VALUE_BITS_DEF,
    parameter int DIGIT_POSITIONS = b2d_pkg::DIGIT_POSITIONS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  b2d_pkg::q_status_t                        q_status,
    input  logic [VALUE_BITS-1:0]                     q_value,
    output logic                                      pop,
    output logic                                      full,
    output logic [DIGIT_POSITIONS*b2d_pkg::DIGIT_W-1:0] bcd,
    input  logic                                      take
);
    import b2d_pkg::*;

    localparam int STEPS = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int PAD_W = STEPS * BITS_PER_STEP;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int BCD_W = DIGIT_POSITIONS * DIGIT_W;

    logic             run_reg, run_next;
    logic             full_reg, full_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [PAD_W-1:0] shift_reg, shift_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic [BCD_W-1:0] bcd_step;
    logic             last_step;

    assign full      = full_reg;
    assign bcd       = bcd_reg;
    assign last_step = (step_reg == CNT_W'(STEPS - 1));

    // take the next item when no conversion runs and the held result is gone or leaving
    assign pop = q_status.valid && !run_reg && (!full_reg || take);

    // several dabble steps: adjust each digit, then shift in one bit
    // the carry out of the top digit is dropped, keeping the low digits
    always_comb
    begin
        bcd_step = bcd_reg;
        for (int b = 0; b < BITS_PER_STEP; b++)
        begin
            for (int d = 0; d < DIGIT_POSITIONS; d++)
            begin
                if (bcd_step[d*DIGIT_W +: DIGIT_W] >= DABBLE_LIMIT)
                begin
                    bcd_step[d*DIGIT_W +: DIGIT_W] =
                        bcd_step[d*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
                end
            end
            bcd_step = {bcd_step[BCD_W-2:0], shift_reg[PAD_W-1-b]};
        end
    end

    // converter sequencing
    always_comb
    begin
        run_next   = run_reg;
        full_next  = full_reg && !take;
        step_next  = step_reg;
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        if (pop)
        begin
            bcd_next = '0;
            if (q_status.zero)
            begin
                full_next = 1'b1;
            end
            else
            begin
                run_next   = 1'b1;
                step_next  = '0;
                shift_next = PAD_W'(q_value);
            end
        end
        else if (run_reg)
        begin
            bcd_next   = bcd_step;
            shift_next = shift_reg << BITS_PER_STEP;
            step_next  = step_reg + 1'b1;
            if (last_step)
            begin
                run_next  = 1'b0;
                full_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            full_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            full_reg <= full_next;
            step_reg <= step_next;
        end
    end

    // working value and digits
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
    end

`ifndef SYNTHESIS
    a_run_or_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(run_reg && full_reg))
        else $error("converter running over a held result");

    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg && last_step) |=> (full_reg && !run_reg))
        else $error("conversion did not complete");
`endif

endmodule

>>> rtl/core/b2d_emit.sv
// back part, second stage: leading zero suppression and character output
module b2d_emit #(
    parameter int DIGIT_POSITIONS = b2d_pkg::DIGIT_POSITIONS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        full,
    input  logic [DIGIT_POSITIONS*b2d_pkg::DIGIT_W-1:0] bcd,
    output logic                                        take,
    output logic                                        strobe,
    output logic [b2d_pkg::CHAR_W-1:0]                  digit_char,
    output logic                                        last
);
    import b2d_pkg::*;

    localparam int IDX_W = $clog2(DIGIT_POSITIONS);
    localparam int BCD_W = DIGIT_POSITIONS * DIGIT_W;

    logic                active_reg, active_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [BCD_W-1:0]    digits_reg, digits_next;
    logic                strobe_reg, strobe_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic                last_reg, last_next;
    logic [IDX_W-1:0]    top_idx;
    logic [DIGIT_W-1:0]  cur_digit;

    assign strobe     = strobe_reg;
    assign digit_char = char_reg;
    assign last       = last_reg;

    // next result is taken while the final digit of the current one goes out
    assign take = full && (!active_reg || (idx_reg == '0));

    // most significant non-zero digit, zero when all digits are zero
    always_comb
    begin
        top_idx = '0;
        for (int k = 1; k < DIGIT_POSITIONS; k++)
        begin
            if (bcd[k*DIGIT_W +: DIGIT_W] != '0)
            begin
                top_idx = IDX_W'(k);
            end
        end
    end

    assign cur_digit = digits_reg[{idx_reg, 2'b00} +: DIGIT_W];

    // walk down from the top digit, one character per cycle
    always_comb
    begin
        active_next = take || (active_reg && (idx_reg != '0));
        idx_next    = idx_reg;
        digits_next = digits_reg;
        strobe_next = active_reg;
        char_next   = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, cur_digit};
        last_next   = (idx_reg == '0);
        if (take)
        begin
            idx_next    = top_idx;
            digits_next = bcd;
        end
        else if (active_reg)
        begin
            idx_next = idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    // held digits and output character
    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

`ifndef SYNTHESIS
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> ((char_reg >= ASCII_ZERO) && (char_reg <= (ASCII_ZERO + 6'd9))))
        else $error("output character is not a decimal digit");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !last_reg) |-> active_reg)
        else $error("digit run ended without a final digit");
`endif

endmodule

>>> rtl/core/binary_to_decimal_ascii.sv
// top level of the binary to decimal ascii converter
//
// Usage: drive value and raise start; the item is accepted at a rising edge
// where start is high and busy is low. busy rises only while the two-entry
// item queue is full. Each accepted value comes out as its decimal digits in
// ascii, most significant first, leading zeros suppressed (zero gives one
// '0'); each character is valid for exactly one cycle with strobe high, and
// last marks the least significant digit of the value. The receiver cannot
// stall: characters go out as they are produced.
// The converter folds four binary bits per cycle; each item passes the queue,
// the converter loop and the output character register before its first
// character strobes, and a zero value skips the converter loop. The item
// rate is set by the digit-per-cycle output stage and the converter loop;
// conversion of one item overlaps output of the last.
// Reset: queue, converter and output stage empty, strobe low.
module binary_to_decimal_ascii #(
    parameter int VALUE_BITS      = b2d_pkg::VALUE_BITS_DEF,
    parameter int DIGIT_POSITIONS = b2d_pkg::DIGIT_POSITIONS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [VALUE_BITS-1:0]      value,
    output logic                       strobe,
    output logic [b2d_pkg::CHAR_W-1:0] digit_char,
    output logic                       last
);
    import b2d_pkg::*;

    localparam int BCD_W = DIGIT_POSITIONS * DIGIT_W;

    q_status_t             q_status;
    logic [VALUE_BITS-1:0] q_value;
    logic                  pop;
    logic                  conv_full;
    logic [BCD_W-1:0]      conv_bcd;
    logic                  take;

    // intake and item queue
    b2d_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .value    (value),
        .q_status (q_status),
        .q_value  (q_value),
        .pop      (pop)
    );

    // binary to bcd conversion
    b2d_conv #(
        .VALUE_BITS      (VALUE_BITS),
        .DIGIT_POSITIONS (DIGIT_POSITIONS)
    ) u_conv (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_value  (q_value),
        .pop      (pop),
        .full     (conv_full),
        .bcd      (conv_bcd),
        .take     (take)
    );

    // character output
    b2d_emit #(
        .DIGIT_POSITIONS (DIGIT_POSITIONS)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .full       (conv_full),
        .bcd        (conv_bcd),
        .take       (take),
        .strobe     (strobe),
        .digit_char (digit_char),
        .last       (last)
    );

endmodule

>>> verif/tb_top.sv
// testbench for the binary to decimal ascii converter
`timescale 1ns / 100ps

module tb_top;

    import b2d_pkg::*;

    localparam int VALUE_BITS      = VALUE_BITS_DEF;
    localparam int DIGIT_POSITIONS = DIGIT_POSITIONS_DEF;
    localparam longint unsigned MAX_VALUE = (64'd1 << VALUE_BITS) - 1;
    localparam int RADIX           = 10;
    localparam int STALL_LIMIT     = 500;
    localparam int DRAIN_CYCLES    = 24;
    localparam int RANDOM_ITEMS    = 88;
    localparam int QUIET_TAIL      = 25;

    // one expected output character
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_exp_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [VALUE_BITS-1:0] value;
    logic                  strobe;
    logic [CHAR_W-1:0]     digit_char;
    logic                  last;

    char_exp_t chars_due[$];
    int        error_count = 0;
    int        quiet_cycles = 0;
    bit        gaps_on = 1'b0;

    binary_to_decimal_ascii #(
        .VALUE_BITS      (VALUE_BITS),
        .DIGIT_POSITIONS (DIGIT_POSITIONS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .strobe     (strobe),
        .digit_char (digit_char),
        .last       (last)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // decimal digits of one value, most significant first, leading zeros dropped
    function automatic void predict_chars(input logic [VALUE_BITS-1:0] v);
        logic [3:0]      dec [DIGIT_POSITIONS];
        longint unsigned rest;
        int              top;
        char_exp_t       e;
        rest = v;
        top  = 0;
        for (int k = 0; k < DIGIT_POSITIONS; k++)
        begin
            dec[k] = 4'(rest % RADIX);
            rest   = rest / RADIX;
            if (dec[k] != 4'd0)
                top = k;
        end
        for (int k = top; k >= 0; k--)
        begin
            e.ch   = ASCII_ZERO + CHAR_W'(dec[k]);
            e.last = (k == 0);
            chars_due = {chars_due, e};
        end
    endfunction

    // random value, mostly spread evenly over the number of digits
    function automatic logic [VALUE_BITS-1:0] pick_value();
        int unsigned     mode;
        int unsigned     ndig;
        longint unsigned lo;
        longint unsigned hi;
        mode = $urandom_range(0, 9);
        if (mode < 6)
        begin
            ndig = $urandom_range(1, DIGIT_POSITIONS);
            lo   = 1;
            repeat (ndig - 1) lo = lo * RADIX;
            hi   = lo * RADIX - 1;
            if (hi > MAX_VALUE)
                hi = MAX_VALUE;
            if (ndig == 1)
                lo = 0;
            return VALUE_BITS'(lo + (longint'($urandom) % (hi - lo + 1)));
        end
        else if (mode < 8)
            return VALUE_BITS'($urandom);
        else if (mode == 8)
            return VALUE_BITS'($urandom_range(0, 20));
        else
        begin
            // next to a power of ten
            ndig = $urandom_range(1, DIGIT_POSITIONS - 1);
            lo   = 1;
            repeat (ndig) lo = lo * RADIX;
            return VALUE_BITS'(lo + $urandom_range(0, 2) - 1);
        end
    endfunction

    // offer one item and hold it until the block takes it
    task automatic send_value(input logic [VALUE_BITS-1:0] v);
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        predict_chars(v);
    endtask

    // random gap on the sending side
    task automatic maybe_gap();
        if (gaps_on && $urandom_range(0, 2) == 0)
        begin
            start <= 1'b0;
            value <= VALUE_BITS'($urandom);
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // zero and the extremes of the value range
    task automatic test_extremes();
        send_value('0);
        maybe_gap();
        send_value(VALUE_BITS'(MAX_VALUE));
        maybe_gap();
        send_value(VALUE_BITS'(1));
        maybe_gap();
        send_value(VALUE_BITS'(1) << (VALUE_BITS - 1));
        maybe_gap();
        send_value(VALUE_BITS'(MAX_VALUE) >> 1);
        maybe_gap();
        send_value(VALUE_BITS'(64'h5555_5555));
        maybe_gap();
        send_value(VALUE_BITS'(64'h2AAA_AAAA));
    endtask

    // digit count boundaries and inner zeros
    task automatic test_digit_boundaries();
        send_value(VALUE_BITS'(9));
        maybe_gap();
        send_value(VALUE_BITS'(10));
        maybe_gap();
        send_value(VALUE_BITS'(99));
        maybe_gap();
        send_value(VALUE_BITS'(100));
        maybe_gap();
        send_value(VALUE_BITS'(999_999_999));
        maybe_gap();
        send_value(VALUE_BITS'(1_000_000_000));
        maybe_gap();
        send_value(VALUE_BITS'(2_000_000_000));
        maybe_gap();
        send_value(VALUE_BITS'(1_234_567_890));
    endtask

    // items offered with no gap so the queue fills and busy rises
    task automatic test_back_to_back();
        send_value(VALUE_BITS'(0));
        send_value(VALUE_BITS'(5));
        send_value(VALUE_BITS'(MAX_VALUE));
        send_value(VALUE_BITS'(0));
        send_value(VALUE_BITS'(1_000_000_001));
        send_value(VALUE_BITS'(70));
        send_value(VALUE_BITS'(1_999_999_999));
    endtask

    // random values, gaps in stretches, none in the tail
    task automatic test_random_values();
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 15 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            if (n >= RANDOM_ITEMS - QUIET_TAIL)
                gaps_on = 1'b0;
            send_value(pick_value());
            maybe_gap();
        end
    endtask

    // result check and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe)
            begin
                if (chars_due.size() == 0)
                begin
                    $error("unexpected character: digit_char %0d, last %0b", digit_char, last);
                    error_count++;
                end
                else
                begin
                    if (digit_char !== chars_due[0].ch)
                    begin
                        $error("digit_char mismatch: expected %0d, actual %0d",
                               chars_due[0].ch, digit_char);
                        error_count++;
                    end
                    if (last !== chars_due[0].last)
                    begin
                        $error("last mismatch: expected %0b, actual %0b",
                               chars_due[0].last, last);
                        error_count++;
                    end
                    void'(chars_due.pop_front());
                end
            end
            if (strobe || (start && !busy))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    // test sequence
    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        value <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gaps_on = 1'b1;
        test_extremes();
        test_digit_boundaries();
        test_back_to_back();
        test_random_values();
        start <= 1'b0;

        // let the last characters come out
        while (chars_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
